FILE: design/spdsq_pkg.sv
// spdsq_pkg: shared constants, operand tables and sizes for the segment pair distance unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package spdsq_pkg;

  // field sizes
  localparam int COORD_WIDTH_DEF = 20;
  localparam int NUM_COORDS      = 8;
  localparam int TOL_WIDTH       = 8;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 8'd1;

  // result field
  localparam int DIST_WIDTH = 41;
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};
  localparam int OUT_TDATA_WIDTH = ((DIST_WIDTH + 7) / 8) * 8;

  // difference vectors: minuend point and subtrahend point (A=0, B=1, C=2, D=3)
  // r = B-A, s = D-C, u = C-A, v = D-A, e = B-C, z = B-D
  localparam int NUM_VECS  = 6;
  localparam int NUM_COMPS = 2 * NUM_VECS;
  localparam int VEC_P [NUM_VECS] = '{1, 3, 2, 3, 1, 1};
  localparam int VEC_Q [NUM_VECS] = '{0, 2, 0, 0, 2, 3};

  // component indexes
  localparam int RX = 0, RY = 1, SX = 2, SY = 3, UX = 4, UY = 5;
  localparam int VX = 6, VY = 7, EX = 8, EY = 9, ZX = 10, ZY = 11;

  // sums, each built from two products; crosses come first and subtract
  localparam int NUM_SUMS  = 15;
  localparam int NUM_CROSS = 5;
  localparam int NUM_PRODS = 2 * NUM_SUMS;
  localparam int S_X_RS  = 0;
  localparam int S_X_UR  = 1;
  localparam int S_X_US  = 2;
  localparam int S_X_ES  = 3;
  localparam int S_X_VR  = 4;
  localparam int S_D_US  = 5;
  localparam int S_D_ES  = 6;
  localparam int S_D_UR  = 7;
  localparam int S_D_VR  = 8;
  localparam int S_L_R   = 9;
  localparam int S_L_S   = 10;
  localparam int S_L_U   = 11;
  localparam int S_L_V   = 12;
  localparam int S_L_E   = 13;
  localparam int S_L_Z   = 14;

  localparam int PROD_A [NUM_PRODS] = '{
    RX, RY,  UX, UY,  UX, UY,  EX, EY,  VX, VY,
    UX, UY,  EX, EY,  UX, UY,  VX, VY,
    RX, RY,  SX, SY,  UX, UY,  VX, VY,  EX, EY,  ZX, ZY};
  localparam int PROD_B [NUM_PRODS] = '{
    SY, SX,  RY, RX,  SY, SX,  SY, SX,  RY, RX,
    SX, SY,  SX, SY,  RX, RY,  RX, RY,
    RX, RY,  SX, SY,  UX, UY,  VX, VY,  EX, EY,  ZX, ZY};

  // point-to-segment lanes
  localparam int NUM_LANES = 4;
  // classify, two squaring stages, saturation check, one stage per quotient bit
  localparam int LANE_LATENCY = 4 + DIST_WIDTH;
  localparam int FRONT_LATENCY = 3;
  localparam int MIN_LATENCY = 2;
  localparam int TOTAL_LATENCY = FRONT_LATENCY + LANE_LATENCY + MIN_LATENCY;

endpackage

FILE: design/segment_pair_distance_sq_unit.sv
// pipeline: input transfer to result through the front stages, the lanes, then the minimum and output registers
// throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or its result is taken, the lane dividers set the depth
// reset (rst, synchronous): clears all valid bits and sets the tolerance to 1
// top level: segment pair squared distance; depends on spdsq_pkg, spdsq_front, spdsq_lane
`timescale 1ns / 1ps

module segment_pair_distance_sq_unit #(
  parameter int COORD_WIDTH = spdsq_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y (low to high)
  input  logic [spdsq_pkg::NUM_COORDS*COORD_WIDTH-1:0] s_axis_tdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // distance_squared, zero fill
  output logic [spdsq_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  // segments_cross
  output logic [0:0] m_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [spdsq_pkg::TOL_WIDTH-1:0] cfg_data,
  input  logic cfg_valid,
  output logic cfg_ready
);
  import spdsq_pkg::*;

  localparam int SW = 2 * (COORD_WIDTH + 1) + 1;

  logic                  adv;
  logic [TOL_WIDTH-1:0]  tol;
  logic [TOTAL_LATENCY-1:0] vld;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = vld[TOTAL_LATENCY-1];

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOTAL_LATENCY-2:0], s_axis_tvalid};
    end
  end

  logic signed [SW-1:0] sums [NUM_SUMS];

  spdsq_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .SUM_WIDTH   (SW)
  ) u_front (
    .clk    (clk),
    .adv    (adv),
    .coords (s_axis_tdata),
    .sums   (sums)
  );

  // intersection test
  logic signed [SW-1:0] tol_s, denom, numer, tnum, rr, p0, p1, lo, hi;
  logic [SW-1:0]        denom_abs, numer_abs;
  logic                 par, in_t, in_u, meet_c;

  assign tol_s = $signed(SW'(tol));
  assign denom = sums[S_X_RS];
  assign numer = sums[S_X_UR];
  assign tnum  = sums[S_X_US];
  assign rr    = sums[S_L_R];
  assign p0    = sums[S_D_UR];
  assign p1    = sums[S_D_VR];
  assign lo    = (p0 < p1) ? p0 : p1;
  assign hi    = (p0 < p1) ? p1 : p0;
  assign denom_abs = denom[SW-1] ? SW'(-denom) : SW'(denom);
  assign numer_abs = numer[SW-1] ? SW'(-numer) : SW'(numer);
  assign par   = denom_abs <= SW'(tol);
  assign in_t  = (denom > 0) ? (tnum >= 0 && tnum <= denom) : (tnum <= 0 && tnum >= denom);
  assign in_u  = (denom > 0) ? (numer >= 0 && numer <= denom)
                             : (numer <= 0 && numer >= denom);

  always_comb begin
    if (!par) begin
      meet_c = in_t && in_u;
    end else if (numer_abs > SW'(tol)) begin
      meet_c = 1'b0;
    end else if (rr <= tol_s) begin
      meet_c = sums[S_L_U] <= tol_s;
    end else begin
      meet_c = (lo <= rr) && (hi >= 0);
    end
  end

  // flag delay matched to the lanes
  logic meet_d [LANE_LATENCY];
  always_ff @(posedge clk) begin
    if (adv) begin
      meet_d[0] <= meet_c;
    end
  end
  for (genvar k = 1; k < LANE_LATENCY; k++) begin : g_meet
    always_ff @(posedge clk) begin
      if (adv) begin
        meet_d[k] <= meet_d[k-1];
      end
    end
  end

  // four endpoint-to-segment lanes: A and B onto CD, C and D onto AB
  logic signed [SW-1:0] l_len [NUM_LANES];
  logic signed [SW-1:0] l_num [NUM_LANES];
  logic signed [SW-1:0] l_crs [NUM_LANES];
  logic signed [SW-1:0] l_ds  [NUM_LANES];
  logic signed [SW-1:0] l_de  [NUM_LANES];
  logic [DIST_WIDTH-1:0] l_dist [NUM_LANES];

  assign l_len[0] = sums[S_L_S];
  assign l_num[0] = -sums[S_D_US];
  assign l_crs[0] = sums[S_X_US];
  assign l_ds[0]  = sums[S_L_U];
  assign l_de[0]  = sums[S_L_V];

  assign l_len[1] = sums[S_L_S];
  assign l_num[1] = sums[S_D_ES];
  assign l_crs[1] = sums[S_X_ES];
  assign l_ds[1]  = sums[S_L_E];
  assign l_de[1]  = sums[S_L_Z];

  assign l_len[2] = sums[S_L_R];
  assign l_num[2] = sums[S_D_UR];
  assign l_crs[2] = sums[S_X_UR];
  assign l_ds[2]  = sums[S_L_U];
  assign l_de[2]  = sums[S_L_E];

  assign l_len[3] = sums[S_L_R];
  assign l_num[3] = sums[S_D_VR];
  assign l_crs[3] = sums[S_X_VR];
  assign l_ds[3]  = sums[S_L_V];
  assign l_de[3]  = sums[S_L_Z];

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    spdsq_lane #(
      .SUM_WIDTH (SW)
    ) u_lane (
      .clk        (clk),
      .adv        (adv),
      .tol        (tol),
      .len_sq     (l_len[k]),
      .num        (l_num[k]),
      .crs        (l_crs[k]),
      .dist_start (l_ds[k]),
      .dist_end   (l_de[k]),
      .dist_sq    (l_dist[k])
    );
  end

  // minimum tree, first level
  logic [DIST_WIDTH-1:0] min01, min23;
  logic                  meet_m;
  always_ff @(posedge clk) begin
    if (adv) begin
      min01  <= (l_dist[1] < l_dist[0]) ? l_dist[1] : l_dist[0];
      min23  <= (l_dist[3] < l_dist[2]) ? l_dist[3] : l_dist[2];
      meet_m <= meet_d[LANE_LATENCY-1];
    end
  end

  // output register
  logic [DIST_WIDTH-1:0] out_dist;
  logic                  out_cross;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_cross <= meet_m;
      if (meet_m) begin
        out_dist <= '0;
      end else begin
        out_dist <= (min23 < min01) ? min23 : min01;
      end
    end
  end

  assign m_axis_tdata = OUT_TDATA_WIDTH'(out_dist);
  assign m_axis_tuser = out_cross;

endmodule

FILE: design/spdsq_front.sv
// spdsq_front: difference, product and sum stages of the segment pair distance unit
// depends on spdsq_pkg
`timescale 1ns / 1ps

module spdsq_front #(
  parameter int COORD_WIDTH = spdsq_pkg::COORD_WIDTH_DEF,
  parameter int SUM_WIDTH   = 2 * (COORD_WIDTH + 1) + 1
) (
  input  logic                                     clk,
  input  logic                                     adv,
  input  logic [spdsq_pkg::NUM_COORDS*COORD_WIDTH-1:0] coords,
  output logic signed [SUM_WIDTH-1:0]              sums [spdsq_pkg::NUM_SUMS]
);
  import spdsq_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] comp [NUM_COMPS];
  logic signed [PW-1:0] prod [NUM_PRODS];

  // stage 1: endpoint differences
  for (genvar k = 0; k < NUM_VECS; k++) begin : g_vec
    for (genvar ax = 0; ax < 2; ax++) begin : g_ax
      logic signed [COORD_WIDTH-1:0] pa, pb;
      assign pa = $signed(coords[(2*VEC_P[k]+ax)*COORD_WIDTH +: COORD_WIDTH]);
      assign pb = $signed(coords[(2*VEC_Q[k]+ax)*COORD_WIDTH +: COORD_WIDTH]);
      always_ff @(posedge clk) begin
        if (adv) begin
          comp[2*k+ax] <= DW'(pa) - DW'(pb);
        end
      end
    end
  end

  // stage 2: component products
  for (genvar k = 0; k < NUM_PRODS; k++) begin : g_prod
    always_ff @(posedge clk) begin
      if (adv) begin
        prod[k] <= comp[PROD_A[k]] * comp[PROD_B[k]];
      end
    end
  end

  // stage 3: cross products, dot products and squared lengths
  for (genvar j = 0; j < NUM_SUMS; j++) begin : g_sum
    always_ff @(posedge clk) begin
      if (adv) begin
        if (j < NUM_CROSS) begin
          sums[j] <= SUM_WIDTH'(prod[2*j]) - SUM_WIDTH'(prod[2*j+1]);
        end else begin
          sums[j] <= SUM_WIDTH'(prod[2*j]) + SUM_WIDTH'(prod[2*j+1]);
        end
      end
    end
  end

endmodule

FILE: design/spdsq_lane.sv
// spdsq_lane: squared distance from a point to a segment, pipelined with a
// one-bit-per-stage restoring divider; depends on spdsq_pkg
`timescale 1ns / 1ps

module spdsq_lane #(
  parameter int SUM_WIDTH = 2 * (spdsq_pkg::COORD_WIDTH_DEF + 1) + 1
) (
  input  logic                                clk,
  input  logic                                adv,
  input  logic [spdsq_pkg::TOL_WIDTH-1:0]     tol,
  input  logic signed [SUM_WIDTH-1:0]         len_sq,
  input  logic signed [SUM_WIDTH-1:0]         num,
  input  logic signed [SUM_WIDTH-1:0]         crs,
  input  logic signed [SUM_WIDTH-1:0]         dist_start,
  input  logic signed [SUM_WIDTH-1:0]         dist_end,
  output logic [spdsq_pkg::DIST_WIDTH-1:0]    dist_sq
);
  import spdsq_pkg::*;

  localparam int SW = SUM_WIDTH;
  localparam int NW = 2 * SW;
  localparam int RW = (NW > SW + DIST_WIDTH) ? NW : SW + DIST_WIDTH;
  localparam int XW = SW + DIST_WIDTH;
  localparam int H  = (SW + 1) / 2;
  localparam int HW = SW - H;

  // classification
  logic signed [SW-1:0] tol_s;
  logic                 use_start, use_end;
  logic [SW-1:0]        pick;
  logic [XW-1:0]        pick_x;

  assign tol_s     = $signed(SW'(tol));
  assign use_start = (len_sq <= tol_s) || (num <= 0);
  assign use_end   = !use_start && (num >= len_sq);
  assign pick      = use_start ? dist_start : dist_end;
  assign pick_x    = XW'(pick);

  logic                  c_div;
  logic [DIST_WIDTH-1:0] c_direct;
  logic [SW-1:0]         c_mag, c_den;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_div    <= !use_start && !use_end;
      c_direct <= (pick_x > XW'(DIST_MAX)) ? DIST_MAX : pick_x[DIST_WIDTH-1:0];
      c_mag    <= crs[SW-1] ? SW'(-crs) : SW'(crs);
      c_den    <= len_sq;
    end
  end

  // squaring, split in halves
  logic [2*HW-1:0]       q_hh;
  logic [HW+H-1:0]       q_hl;
  logic [2*H-1:0]        q_ll;
  logic                  q_div;
  logic [DIST_WIDTH-1:0] q_direct;
  logic [SW-1:0]         q_den;

  always_ff @(posedge clk) begin
    if (adv) begin
      q_hh     <= c_mag[SW-1:H] * c_mag[SW-1:H];
      q_hl     <= c_mag[SW-1:H] * c_mag[H-1:0];
      q_ll     <= c_mag[H-1:0] * c_mag[H-1:0];
      q_div    <= c_div;
      q_direct <= c_direct;
      q_den    <= c_den;
    end
  end

  logic [NW-1:0]         n_sq;
  logic                  n_div;
  logic [DIST_WIDTH-1:0] n_direct;
  logic [SW-1:0]         n_den;

  always_ff @(posedge clk) begin
    if (adv) begin
      n_sq     <= (NW'(q_hh) << (2 * H)) + (NW'(q_hl) << (H + 1)) + NW'(q_ll);
      n_div    <= q_div;
      n_direct <= q_direct;
      n_den    <= q_den;
    end
  end

  // divider stages: index 0 is the saturation check output
  logic [RW-1:0]         rem_p    [DIST_WIDTH+1];
  logic [DIST_WIDTH-1:0] quo_p    [DIST_WIDTH+1];
  logic [SW-1:0]         den_p    [DIST_WIDTH+1];
  logic                  sat_p    [DIST_WIDTH+1];
  logic                  div_p    [DIST_WIDTH+1];
  logic [DIST_WIDTH-1:0] direct_p [DIST_WIDTH+1];

  // quotient would not fit in the result field
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_p[0]    <= RW'(n_sq);
      quo_p[0]    <= '0;
      den_p[0]    <= n_den;
      sat_p[0]    <= RW'(n_sq) >= (RW'(n_den) << DIST_WIDTH);
      div_p[0]    <= n_div;
      direct_p[0] <= n_direct;
    end
  end

  for (genvar k = 0; k < DIST_WIDTH; k++) begin : g_div
    localparam int BIT = DIST_WIDTH - 1 - k;
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(den_p[k]) << BIT;
    assign take = rem_p[k] >= dsh;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_p[k+1]    <= take ? rem_p[k] - dsh : rem_p[k];
        quo_p[k+1]    <= {quo_p[k][DIST_WIDTH-2:0], take};
        den_p[k+1]    <= den_p[k];
        sat_p[k+1]    <= sat_p[k];
        div_p[k+1]    <= div_p[k];
        direct_p[k+1] <= direct_p[k];
      end
    end
  end

  // perpendicular foot or clamped endpoint
  assign dist_sq = !div_p[DIST_WIDTH] ? direct_p[DIST_WIDTH]
                 : (sat_p[DIST_WIDTH] ? DIST_MAX : quo_p[DIST_WIDTH]);

endmodule

FILE: design/spdsq_checker.sv
// spdsq_checker: port-level assertions for segment_pair_distance_sq_unit
// depends on spdsq_pkg; attached to the top level by the bind below
`timescale 1ns / 1ps

module spdsq_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [spdsq_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  input logic [0:0] m_axis_tuser
);
  import spdsq_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // crossing segments report zero distance
  a_cross_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("crossing with nonzero distance");

  // an empty output stage never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // fill bits above the distance stay zero
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_WIDTH-1:DIST_WIDTH] == '0)
    else $error("nonzero fill bits");

endmodule

bind segment_pair_distance_sq_unit spdsq_checker u_spdsq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
